// File: hdl/shifting_queue_with_search_macros.svh
// Assertion macros for the shifting queue with search.
// Used by modules that check their own control logic; expects clk and arst_n in scope.
`ifndef SHIFTING_QUEUE_WITH_SEARCH_MACROS_SVH
`define SHIFTING_QUEUE_WITH_SEARCH_MACROS_SVH

// property must hold at every clock edge out of reset
`define SQS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SQS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hdl/sqs_pkg.sv
// Shared types and constants for the shifting queue with search.
// No dependencies.
package sqs_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ACT_W = 3;
	localparam int STAT_W = 2;
	localparam int S_DATA_W = ((DATA_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT   = 3'd0,
		ACT_DELETE   = 3'd1,
		ACT_SEARCH   = 3'd2,
		ACT_LIST     = 3'd3,
		ACT_LIST_REV = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic wr;    // write tail cell selected by occupancy
		logic del;   // drop head, everything moves one cell toward the head
		logic load;  // copy entries into scan row and compare against key
		logic dn;    // scan row moves toward the head
		logic up;    // scan row moves toward the tail
	} cell_ctl_t;

endpackage

// File: hdl/sqs_cell.sv
// One queue cell: stored entry plus a scan copy with its match flag.
// Depends on sqs_pkg.
module sqs_cell (
	input  logic              clk,
	input  sqs_pkg::cell_ctl_t ctl,
	input  logic              wr_sel,
	input  logic              in_range,
	input  sqs_pkg::word_t    wr_data,
	input  sqs_pkg::word_t    key,
	input  sqs_pkg::word_t    nbr_entry,
	input  sqs_pkg::word_t    nbr_scan_dn,
	input  logic              nbr_hit_dn,
	input  sqs_pkg::word_t    nbr_scan_up,
	output sqs_pkg::word_t    entry,
	output sqs_pkg::word_t    scan,
	output logic              hit
);
	import sqs_pkg::*;

	word_t entry_q;
	word_t scan_q;
	logic  hit_q;

	always_ff @(posedge clk) begin
		if (ctl.del) begin
			entry_q <= nbr_entry;
		end else if (ctl.wr && wr_sel) begin
			entry_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			scan_q <= entry_q;
			hit_q  <= in_range && (entry_q == key);
		end else if (ctl.dn) begin
			scan_q <= nbr_scan_dn;
			hit_q  <= nbr_hit_dn;
		end else if (ctl.up) begin
			scan_q <= nbr_scan_up;
		end
	end

	assign entry = entry_q;
	assign scan  = scan_q;
	assign hit   = hit_q;

endmodule

// File: hdl/sqs_chain.sv
// Row of DEPTH queue cells, head at cell 0, with head and tail taps.
// Depends on sqs_pkg and sqs_cell.
module sqs_chain (
	input  logic               clk,
	input  sqs_pkg::cell_ctl_t ctl,
	input  sqs_pkg::cnt_t      occ,
	input  sqs_pkg::word_t     wr_data,
	input  sqs_pkg::word_t     key,
	output sqs_pkg::word_t     head_entry,
	output sqs_pkg::word_t     head_scan,
	output logic               head_hit,
	output logic               hit_rest,
	output sqs_pkg::word_t     tail_scan
);
	import sqs_pkg::*;

	word_t entry_w [DEPTH];
	word_t scan_w  [DEPTH];
	logic  [DEPTH-1:0] hit_w;
	cnt_t  tail_cnt;
	idx_t  tail_idx;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t nbr_entry;
		word_t nbr_scan_dn;
		logic  nbr_hit_dn;
		word_t nbr_scan_up;

		if (i == DEPTH - 1) begin : g_tail
			assign nbr_entry   = entry_w[i];
			assign nbr_scan_dn = '0;
			assign nbr_hit_dn  = 1'b0;
		end else begin : g_mid
			assign nbr_entry   = entry_w[i+1];
			assign nbr_scan_dn = scan_w[i+1];
			assign nbr_hit_dn  = hit_w[i+1];
		end

		if (i == 0) begin : g_head
			assign nbr_scan_up = '0;
		end else begin : g_nhead
			assign nbr_scan_up = scan_w[i-1];
		end

		sqs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wr_sel     (occ == CNT_W'(i)),
			.in_range   (CNT_W'(i) < occ),
			.wr_data    (wr_data),
			.key        (key),
			.nbr_entry  (nbr_entry),
			.nbr_scan_dn(nbr_scan_dn),
			.nbr_hit_dn (nbr_hit_dn),
			.nbr_scan_up(nbr_scan_up),
			.entry      (entry_w[i]),
			.scan       (scan_w[i]),
			.hit        (hit_w[i])
		);
	end

	// reverse listing reads the cell at occupancy - 1; the row moves up past it
	assign tail_cnt = occ - CNT_W'(1);
	assign tail_idx = tail_cnt[IDX_W-1:0];

	assign head_entry = entry_w[0];
	assign head_scan  = scan_w[0];
	assign head_hit   = hit_w[0];
	assign hit_rest   = |hit_w[DEPTH-1:1];
	assign tail_scan  = scan_w[tail_idx];

endmodule

// File: hdl/shifting_queue_with_search.sv
// Bounded in-order queue of up to DEPTH (16) signed 32-bit words, head at
// position 1. One item is taken at a time. Insert, delete, and search or list
// on an empty queue give one result once the output register is free.
// Search and list walk a scan copy of the queue through the cell row, one
// position per cycle while the output register is free (search stops after
// its last hit); output back-pressure stalls the walk. The next item is taken
// the cycle after the last result is loaded into the output register.
// Actions 5 to 7 are dropped with no result. Depends on sqs_pkg and sqs_chain.
module shifting_queue_with_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [sqs_pkg::S_DATA_W-1:0] s_axis_tdata,  // data_value
	input  logic [sqs_pkg::ACT_W-1:0]    s_axis_tuser,  // action
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [sqs_pkg::M_DATA_W-1:0] m_axis_tdata,  // value, position, match_count
	output logic [sqs_pkg::STAT_W-1:0]   m_axis_tuser,  // status
	output logic                         m_axis_tlast   // last
);
	import sqs_pkg::*;

	`include "shifting_queue_with_search_macros.svh"

	state_t    state_q, state_nxt;
	action_t   act_q;
	cnt_t      occ_q;
	idx_t      idx_q;
	cnt_t      match_cnt_q;
	word_t     ins_q;

	logic      in_fire;
	logic      act_ok;
	logic      slot_free;
	cell_ctl_t ctl;
	logic      emit;
	logic      done;
	logic      cnt_inc;
	status_t   r_status;
	word_t     r_value;
	cnt_t      r_pos;
	cnt_t      r_cnt;
	logic      r_last;
	cnt_t      pos1;

	word_t     in_value;
	word_t     head_entry;
	word_t     head_scan;
	logic      head_hit;
	logic      hit_rest;
	word_t     tail_scan;

	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	status_t             m_status_q;
	logic                m_last_q;

	assign in_value      = s_axis_tdata[DATA_W-1:0];
	assign act_ok        = (s_axis_tuser <= ACT_W'(ACT_LIST_REV));
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !m_valid_q || m_axis_tready;
	assign pos1          = CNT_W'(idx_q) + CNT_W'(1);

	sqs_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.occ       (occ_q),
		.wr_data   (ins_q),
		.key       (in_value),
		.head_entry(head_entry),
		.head_scan (head_scan),
		.head_hit  (head_hit),
		.hit_rest  (hit_rest),
		.tail_scan (tail_scan)
	);

	// Insert writes the value latched on the bus: tready is low in RUN, so
	// the data is held by the source only until accept; keep a copy.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ins_q <= in_value;
		end
	end

	always_comb begin
		ctl      = '0;
		emit     = 1'b0;
		done     = 1'b0;
		cnt_inc  = 1'b0;
		r_status = STAT_OK;
		r_value  = '0;
		r_pos    = '0;
		r_cnt    = '0;
		r_last   = 1'b0;
		ctl.load = in_fire && act_ok;
		if (state_q == ST_RUN && slot_free) begin
			if (occ_q == '0 && act_q != ACT_INSERT) begin
				emit     = 1'b1;
				done     = 1'b1;
				r_last   = 1'b1;
				r_status = STAT_EMPTY;
			end else begin
				unique case (act_q)
					ACT_INSERT: begin
						emit   = 1'b1;
						done   = 1'b1;
						r_last = 1'b1;
						if (occ_q < CNT_W'(DEPTH)) begin
							ctl.wr = 1'b1;
						end else begin
							r_status = STAT_FULL;
						end
					end
					ACT_DELETE: begin
						emit    = 1'b1;
						done    = 1'b1;
						r_last  = 1'b1;
						r_value = head_entry;
						ctl.del = 1'b1;
					end
					ACT_SEARCH: begin
						ctl.dn = 1'b1;
						if (head_hit) begin
							emit    = 1'b1;
							cnt_inc = 1'b1;
							r_value = head_scan;
							r_pos   = pos1;
							if (!hit_rest) begin
								r_last = 1'b1;
								r_cnt  = match_cnt_q + CNT_W'(1);
								done   = 1'b1;
							end
						end else if (!hit_rest && match_cnt_q == '0) begin
							// nothing left to find
							emit     = 1'b1;
							done     = 1'b1;
							r_last   = 1'b1;
							r_status = STAT_NOTFOUND;
						end
					end
					ACT_LIST: begin
						emit    = 1'b1;
						ctl.dn  = 1'b1;
						r_value = head_scan;
						r_pos   = pos1;
						r_last  = (pos1 == occ_q);
						done    = r_last;
					end
					ACT_LIST_REV: begin
						emit    = 1'b1;
						ctl.up  = 1'b1;
						r_value = tail_scan;
						r_pos   = occ_q - CNT_W'(idx_q);
						r_last  = (pos1 == occ_q);
						done    = r_last;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && act_ok) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_INSERT;
			occ_q       <= '0;
			idx_q       <= '0;
			match_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_fire && act_ok) begin
				act_q       <= action_t'(s_axis_tuser);
				idx_q       <= '0;
				match_cnt_q <= '0;
			end else begin
				if (ctl.dn || ctl.up) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (cnt_inc) begin
					match_cnt_q <= match_cnt_q + CNT_W'(1);
				end
			end
			if (ctl.wr) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (ctl.del) begin
				occ_q <= occ_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q   <= M_DATA_W'({r_cnt, r_pos, r_value});
			m_status_q <= r_status;
			m_last_q   <= r_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

	`SQS_NEVER(a_occ_max, occ_q > CNT_W'(DEPTH), "occupancy above capacity")
	`SQS_ASSERT(a_occ_src, occ_q != $past(occ_q) |-> $past(ctl.wr || ctl.del), "occupancy moved without insert or delete")
	`SQS_ASSERT(a_last_idle, emit && r_last |=> state_q == ST_IDLE, "final result did not end the item")
	`SQS_ASSERT(a_scan_rng, state_q == ST_RUN && occ_q != '0 && (ctl.dn || ctl.up) |-> pos1 <= occ_q, "scan ran past occupancy")

endmodule
